### rtl/tst_pkg.sv
package tst_pkg;

   localparam int SLOT_COUNT_DEFAULT = 16;
   localparam int COMMAND_W = 2;
   localparam int IDENTITY_W = 64;
   localparam int SLOT_INDEX_W = 4;
   localparam int ACTIVE_COUNT_W = 5;

   typedef enum logic [1:0] {
      CMD_ACQUIRE     = 2'd0,
      CMD_FIND        = 2'd1,
      CMD_RELEASE     = 2'd2,
      CMD_RELEASE_ALL = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_read;
      logic scan_compare;
      logic commit;
   } ctl_type;

   typedef struct packed {
      logic skip_scan;
      logic scan_last;
   } status_type;

endpackage

### rtl/touch_slot_table_core.sv
// Maps nonzero 64-bit touch identities to slot numbers. A command is taken when start is
// high and busy is low. A release-all, or any command with a zero identity, skips the scan and
// goes straight to the commit state; every other command scans the slot table in memory, each
// slot in a read state and then a compare state, and then commits. Each result is driven for
// exactly one cycle with rsp_strobe high, in the cycle in which busy falls; the receiver cannot
// stall it, so it must capture every result in that cycle.
module touch_slot_table_core import tst_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [COMMAND_W-1:0]      req_command,
   input  logic [IDENTITY_W-1:0]     req_identity,
   output logic                      rsp_strobe,
   output logic [SLOT_INDEX_W-1:0]   rsp_slot_index,
   output logic                      rsp_slot_valid,
   output logic [ACTIVE_COUNT_W-1:0] rsp_active_count
);

   ctl_type    ctl;
   status_type status;

   tst_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .ctl    (ctl)
   );

   tst_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_identity     (req_identity),
      .ctl              (ctl),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_slot_valid   (rsp_slot_valid),
      .rsp_active_count (rsp_active_count)
   );

endmodule

### rtl/tst_controller.sv
module tst_controller import tst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output ctl_type    ctl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = status.skip_scan ? ST_COMMIT : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            state_in = status.scan_last ? ST_COMMIT : ST_READ;
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            ctl.load = start;
         end
         ST_READ: begin
            ctl.scan_read = 1'b1;
         end
         ST_COMPARE: begin
            ctl.scan_compare = 1'b1;
         end
         ST_COMMIT: begin
            ctl.commit = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

### rtl/tst_datapath.sv
module tst_datapath import tst_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
   localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [COMMAND_W-1:0]      req_command,
   input  logic [IDENTITY_W-1:0]     req_identity,
   input  ctl_type                   ctl,
   output status_type                status,
   output logic                      rsp_strobe,
   output logic [SLOT_INDEX_W-1:0]   rsp_slot_index,
   output logic                      rsp_slot_valid,
   output logic [ACTIVE_COUNT_W-1:0] rsp_active_count
);

   logic [IDENTITY_W-1:0] slot_mem [SLOT_COUNT];

   command_type           cmd_ff;
   logic [IDENTITY_W-1:0] id_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [IDENTITY_W-1:0] rd_data_ff;
   logic                  match_found_ff;
   logic [IDX_W-1:0]      match_idx_ff;
   logic                  free_found_ff;
   logic [IDX_W-1:0]      free_idx_ff;
   logic [SLOT_COUNT-1:0] valid_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  rsp_strobe_ff;
   logic [SLOT_INDEX_W-1:0]   rsp_index_ff;
   logic                  rsp_valid_ff;
   logic [ACTIVE_COUNT_W-1:0] rsp_count_ff;

   logic                  hit;
   logic [IDX_W-1:0]      hit_idx;
   logic [CNT_W-1:0]      count_in;
   logic                  mem_we;
   logic                  set_valid;
   logic                  clear_valid;
   logic                  clear_all;
   logic                  slot_match;
   logic [IDX_W+SLOT_INDEX_W-1:0]   hit_idx_ext;
   logic [CNT_W+ACTIVE_COUNT_W-1:0] count_ext;

   assign status.skip_scan = (command_type'(req_command) == CMD_RELEASE_ALL) ||
                             (req_identity == '0);
   assign status.scan_last = (idx_ff == IDX_W'(SLOT_COUNT - 1));

   assign slot_match = valid_ff[idx_ff] && (rd_data_ff == id_ff);

   always_ff @(posedge clock) begin
      if (ctl.scan_read) begin
         rd_data_ff <= slot_mem[idx_ff];
      end
      if (mem_we) begin
         slot_mem[free_idx_ff] <= id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= command_type'(req_command);
         id_ff <= req_identity;
         idx_ff <= '0;
         match_found_ff <= 1'b0;
         match_idx_ff <= '0;
         free_found_ff <= 1'b0;
         free_idx_ff <= '0;
      end
      if (ctl.scan_compare) begin
         if (slot_match && !match_found_ff) begin
            match_found_ff <= 1'b1;
            match_idx_ff <= idx_ff;
         end
         if (!valid_ff[idx_ff] && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff <= idx_ff;
         end
         if (!status.scan_last) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      hit = 1'b0;
      hit_idx = '0;
      count_in = count_ff;
      mem_we = 1'b0;
      set_valid = 1'b0;
      clear_valid = 1'b0;
      clear_all = 1'b0;
      case (cmd_ff)
         CMD_ACQUIRE: begin
            if (match_found_ff) begin
               hit = 1'b1;
               hit_idx = match_idx_ff;
            end else if (free_found_ff) begin
               hit = 1'b1;
               hit_idx = free_idx_ff;
               mem_we = ctl.commit;
               set_valid = ctl.commit;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_FIND: begin
            hit = match_found_ff;
            hit_idx = match_found_ff ? match_idx_ff : '0;
         end
         CMD_RELEASE: begin
            if (match_found_ff) begin
               hit = 1'b1;
               hit_idx = match_idx_ff;
               clear_valid = ctl.commit;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         CMD_RELEASE_ALL: begin
            clear_all = ctl.commit;
            count_in = '0;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   assign hit_idx_ext = {{SLOT_INDEX_W{1'b0}}, hit_idx};
   assign count_ext = {{ACTIVE_COUNT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl.commit;
         if (ctl.commit) begin
            count_ff <= count_in;
         end
         if (clear_all) begin
            valid_ff <= '0;
         end else if (set_valid) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end else if (clear_valid) begin
            valid_ff[match_idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_index_ff <= hit_idx_ext[SLOT_INDEX_W-1:0];
         rsp_valid_ff <= hit;
         rsp_count_ff <= count_ext[ACTIVE_COUNT_W-1:0];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_slot_index = rsp_index_ff;
   assign rsp_slot_valid = rsp_valid_ff;
   assign rsp_active_count = rsp_count_ff;

endmodule
